### rtl/tks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants for top-k selection
// Widths, limits, register map and the per-cell entry record.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int MAX_KEEP  = 32;
  localparam int MAX_ITEMS = 65536;

  localparam int SCORE_W = 32;
  localparam int INDEX_W = 16;
  localparam int KEEP_W  = 6;
  localparam int POS_W   = $clog2(MAX_ITEMS + 1);
  localparam int KEFF_W  = (KEEP_W > $clog2(MAX_KEEP + 1)) ? KEEP_W : $clog2(MAX_KEEP + 1);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [0:0]        REG_KEEP_COUNT = 1'b0;
  localparam logic [KEEP_W-1:0] KEEP_RESET     = KEEP_W'(32);

  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] score;
    logic [INDEX_W-1:0] index;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic insert;
    logic last;
    logic shift;
  } cell_ctl_t;

endpackage

### rtl/tks_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tks_in_if: score request channel
// Valid/ready channel carrying one score and the end-of-stream mark.
// ----------------------------------------------------------------------------
interface tks_in_if
  import tks_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;
  logic               last_item;

  modport source (output valid, output score, output last_item, input ready);
  modport sink   (input valid, input score, input last_item, output ready);
endinterface

### rtl/tks_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tks_out_if: ranked result channel
// Valid/ready channel carrying one kept entry per request.
// ----------------------------------------------------------------------------
interface tks_out_if
  import tks_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] top_score;
  logic [INDEX_W-1:0] top_index;
  logic               final_entry;

  modport source (output valid, output top_score, output top_index, output final_entry,
                  input ready);
  modport sink   (input valid, input top_score, input top_index, input final_entry,
                  output ready);
endinterface

### rtl/tks_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tks_cell: one slot of the insertion chain
// Holds one ranked entry and one drain entry. On insert it keeps its entry,
// takes the candidate, or takes its left neighbor's entry. The drain entry
// shifts toward slot 0 on each delivered result.
// ----------------------------------------------------------------------------
module tks_cell
  import tks_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      active,
  input  entry_t    cand,
  input  entry_t    left_ent,
  input  logic      left_disp,
  input  entry_t    right_drain,
  output entry_t    ent,
  output logic      disp,
  output entry_t    drain
);

  entry_t slot;
  entry_t slot_next;

  always_comb begin
    ent       = slot;
    ent.valid = slot.valid && active;
    disp      = !ent.valid || ($signed(cand.score) > $signed(slot.score));
  end

  always_comb begin
    slot_next = ent;
    if (ctl.insert) begin
      if (!active) begin
        slot_next.valid = 1'b0;
      end else if (disp && !left_disp) begin
        slot_next = cand;
      end else if (disp) begin
        slot_next = left_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      slot.score <= slot_next.score;
      slot.index <= slot_next.index;
    end
    if (ctl.accept && ctl.last) begin
      drain.score <= slot_next.score;
      drain.index <= slot_next.index;
    end else if (ctl.shift) begin
      drain.score <= right_drain.score;
      drain.index <= right_drain.index;
    end
    if (rst) begin
      slot.valid  <= 1'b0;
      drain.valid <= 1'b0;
    end else begin
      if (ctl.accept) begin
        slot.valid <= slot_next.valid && !ctl.last;
      end
      if (ctl.accept && ctl.last) begin
        drain.valid <= slot_next.valid;
      end else if (ctl.shift) begin
        drain.valid <= right_drain.valid;
      end
    end
  end

endmodule

### rtl/tks_apb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tks_apb: configuration register port
// Holds keep_count and returns the clamped keep limit for the chain.
// ----------------------------------------------------------------------------
module tks_apb
  import tks_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [KEFF_W-1:0] keep_eff
);

  logic [KEEP_W-1:0] keep_count;
  logic              sel_keep;
  logic [KEFF_W-1:0] keep_ext;

  assign pready   = 1'b1;
  assign sel_keep = (paddr[APB_AW-1:2] == REG_KEEP_COUNT);
  assign prdata   = sel_keep ? APB_DW'(keep_count) : '0;
  assign keep_ext = KEFF_W'(keep_count);

  always_comb begin
    if (keep_count == '0) begin
      keep_eff = KEFF_W'(1);
    end else if (keep_ext > KEFF_W'(MAX_KEEP)) begin
      keep_eff = KEFF_W'(MAX_KEEP);
    end else begin
      keep_eff = keep_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
    end else if (psel && penable && pwrite && pready && sel_keep) begin
      keep_count <= pwdata[KEEP_W-1:0];
    end
  end

endmodule

### rtl/top_k_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_select: streaming top-k selection over signed Q16.16 scores
// Channel   Dir  Content
// item      in   score, last_item (ends the stream)
// result    out  top_score, top_index, final_entry (best first)
// apb       in   keep_count at byte address 0
// One score per cycle: every slot compares the broadcast score in parallel
// and shifts right in the same cycle. On a last item the ranked chain is
// copied into the drain chain, which sends one entry per cycle unless result
// stalls it, and the ranked chain starts empty for the next stream at once.
// A last item waits (ready low) while the previous run is still draining.
// Reset is synchronous and clears all slots; keep_count returns to 32.
// ----------------------------------------------------------------------------
module top_k_select
  import tks_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  tks_in_if.sink            item,
  tks_out_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [KEFF_W-1:0] keep_eff;
  logic [POS_W-1:0]  pos_cnt;
  logic              accept;
  cell_ctl_t         ctl;
  entry_t            cand;

  entry_t ent     [MAX_KEEP];
  logic   disp    [MAX_KEEP];
  entry_t left_ent[MAX_KEEP];
  logic   left_dsp[MAX_KEEP];
  entry_t drain   [MAX_KEEP+1];

  tks_apb u_apb (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .keep_eff (keep_eff)
  );

  assign item.ready = !(item.last_item && drain[0].valid);
  assign accept     = item.valid && item.ready;

  assign ctl.accept = accept;
  assign ctl.insert = accept && (pos_cnt < POS_W'(MAX_ITEMS));
  assign ctl.last   = item.last_item;
  assign ctl.shift  = result.valid && result.ready;

  assign cand.valid = 1'b1;
  assign cand.score = item.score;
  assign cand.index = INDEX_W'(pos_cnt);

  assign drain[MAX_KEEP] = '0;
  assign left_ent[0]     = '0;
  assign left_dsp[0]     = 1'b0;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign left_ent[i] = ent[i-1];
      assign left_dsp[i] = disp[i-1];
    end
    tks_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .active      (KEFF_W'(i) < keep_eff),
      .cand        (cand),
      .left_ent    (left_ent[i]),
      .left_disp   (left_dsp[i]),
      .right_drain (drain[i+1]),
      .ent         (ent[i]),
      .disp        (disp[i]),
      .drain       (drain[i])
    );
  end

  assign result.valid       = drain[0].valid;
  assign result.top_score   = drain[0].score;
  assign result.top_index   = drain[0].index;
  assign result.final_entry = drain[0].valid && !drain[1].valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt <= '0;
    end else if (accept) begin
      if (item.last_item) begin
        pos_cnt <= '0;
      end else if (pos_cnt < POS_W'(MAX_ITEMS)) begin
        pos_cnt <= pos_cnt + POS_W'(1);
      end
    end
  end

endmodule

### rtl/tks_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tks_chk: port-level checks for top_k_select
// Watches the request channels for run framing and output hold.
// ----------------------------------------------------------------------------
module tks_chk
  import tks_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               item_last,
  input logic               res_valid,
  input logic               res_ready,
  input logic [SCORE_W-1:0] res_score,
  input logic               res_final
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_score))
    else $error("result dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_last && !res_valid |=> res_valid)
    else $error("stream ended without a result");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_final |=> res_valid)
    else $error("run cut short before final entry");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_final |=> !res_valid)
    else $error("result after final entry");

endmodule

bind top_k_select tks_chk u_tks_chk (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .item_last  (item.last_item),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_score  (result.top_score),
  .res_final  (result.final_entry)
);

### bench/tks_rank_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tks_rank_checker: ranking predictor and result checker for top_k_select
// Tracks keep_count from APB writes and mirrors the ranked list for every
// accepted score. On each end of stream it queues the ranked entries, best
// first, and compares every accepted result against the oldest one.
// ----------------------------------------------------------------------------
module tks_rank_checker
  import tks_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  tks_in_if                 item,
  tks_out_if                result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                outstanding,
  output int                fail_count
);

  localparam logic [APB_AW-1:0] KEEP_ADDR = APB_AW'(4 * REG_KEEP_COUNT);

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [INDEX_W-1:0] index;
    logic               fin;
  } ranked_t;

  logic signed [SCORE_W-1:0] kept_score [MAX_KEEP];
  logic        [INDEX_W-1:0] kept_index [MAX_KEEP];
  int                        filled;
  int                        position;
  logic        [KEEP_W-1:0] keep_reg;
  ranked_t                   ranked_q [$];

  task automatic rank_score(input logic [SCORE_W-1:0] s, input logic eos);
    int k;
    int slot;
    int lim;
    ranked_t e;
    k = int'(keep_reg);
    if (k < 1) k = 1;
    if (k > MAX_KEEP) k = MAX_KEEP;
    if (filled > k) filled = k;
    if (position < MAX_ITEMS) begin
      slot = 0;
      while (slot < filled && $signed(s) <= kept_score[slot]) slot++;
      if (slot < k) begin
        lim = (filled < k) ? filled : k - 1;
        for (int j = lim; j > slot; j--) begin
          kept_score[j] = kept_score[j-1];
          kept_index[j] = kept_index[j-1];
        end
        kept_score[slot] = s;
        kept_index[slot] = INDEX_W'(position);
        if (filled < k) filled++;
      end
      position++;
    end
    if (eos) begin
      for (int i = 0; i < filled; i++) begin
        e.score = kept_score[i];
        e.index = kept_index[i];
        e.fin   = (i == filled - 1);
        ranked_q = {ranked_q, e};
      end
      filled   = 0;
      position = 0;
    end
  endtask

  task automatic check_result();
    ranked_t want;
    if (ranked_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected result score=%h index=%0d final=%0b", $realtime,
                 result.top_score, result.top_index, result.final_entry);
    end else begin
      want = ranked_q.pop_front();
      if (want.score !== result.top_score || want.index !== result.top_index ||
          want.fin !== result.final_entry) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"%0t: mismatch exp score=%h index=%0d final=%0b",
                    " got score=%h index=%0d final=%0b"},
                   $realtime, want.score, want.index, want.fin,
                   result.top_score, result.top_index, result.final_entry);
      end
    end
  endtask

  initial begin
    fail_count  = 0;
    outstanding = 0;
    filled      = 0;
    position    = 0;
    keep_reg    = KEEP_RESET;
  end

  always @(posedge clk) begin
    if (rst) begin
      filled   = 0;
      position = 0;
      keep_reg = KEEP_RESET;
      ranked_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == KEEP_ADDR)
        keep_reg = pwdata[KEEP_W-1:0];
      if (item.valid && item.ready)
        rank_score(item.score, item.last_item);
      if (result.valid && result.ready)
        check_result();
    end
    outstanding = ranked_q.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for top_k_select
// Drives score streams with random gaps and random result back-pressure,
// sweeps keep_count over its range and extremes, and reports the verdict
// from the ranking checker.
// ----------------------------------------------------------------------------
module tb;
  import tks_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 40;
  localparam int LIMIT       = 400000;
  localparam int PHASE_ITEMS = 33;
  localparam logic [APB_AW-1:0] KEEP_ADDR = APB_AW'(4 * REG_KEEP_COUNT);

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                outstanding;
  int                fail_count;
  int                cycles;
  logic              no_idle;
  int                hold_tokens;
  int                hold_seen;
  int                rx_hold;
  int                rx_gap;
  int                rx_draw;

  tks_in_if  item_ch ();
  tks_out_if result_ch ();

  top_k_select u_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tks_rank_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    item_ch.valid      = 1'b0;
    item_ch.score      = '0;
    item_ch.last_item  = 1'b0;
    result_ch.ready    = 1'b0;
    no_idle            = 1'b0;
    hold_tokens        = 0;
    hold_seen          = 0;
    rx_hold            = 0;
    rx_gap             = 0;
    cycles             = 0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (no_idle || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [SCORE_W-1:0] rand_score();
    int v;
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: begin
        v = int'($urandom_range(0, 8)) - 4;
        return SCORE_W'(v);
      end
      4: return {$urandom_range(0, 3) == 0 ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_gap          <= 0;
    end else if (hold_seen != hold_tokens) begin
      hold_seen       <= hold_seen + 1;
      rx_hold         <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold         <= rx_hold - 1;
      result_ch.ready <= 1'b0;
    end else if (result_ch.ready) begin
      if (result_ch.valid) begin
        rx_draw = draw_gap();
        if (rx_draw > 0) begin
          result_ch.ready <= 1'b0;
          rx_gap          <= rx_draw - 1;
        end
      end
    end else if (rx_gap == 0) begin
      result_ch.ready <= 1'b1;
    end else begin
      rx_gap <= rx_gap - 1;
    end
  end

  task automatic reg_write(input logic [APB_DW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KEEP_ADDR;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_score(input logic [SCORE_W-1:0] s, input logic eos);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.score     <= s;
    item_ch.last_item <= eos;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic drain_all();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(input logic [KEEP_W-1:0] keep_val);
    int k;
    int sent;
    int len;
    k = (keep_val == 0) ? 1 : (keep_val > MAX_KEEP ? MAX_KEEP : int'(keep_val));
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(1, 3);
        1: len = $urandom_range(1, k + 2);
        2: len = $urandom_range(k, 2 * k + 4);
        default: len = $urandom_range(1, 60);
      endcase
      for (int i = 0; i < len; i++) send_score(rand_score(), i == len - 1);
      sent += len;
    end
  endtask

  logic [KEEP_W-1:0] keep_plan [8] = '{6'd1, 6'd32, 6'd63, 6'd5, 6'd0, 6'd17, 6'd2, 6'd31};

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-item stream, most negative score
    send_score(32'h8000_0000, 1'b1);
    // extremes and ties at reset keep_count
    send_score(32'd5, 1'b0);
    send_score(32'd5, 1'b0);
    send_score(32'h7FFF_FFFF, 1'b0);
    send_score(32'h0000_0000, 1'b0);
    send_score(32'hFFFF_FFFF, 1'b0);
    send_score(32'h0001_0000, 1'b0);
    send_score(32'h8000_0000, 1'b0);
    send_score(32'd5, 1'b0);
    send_score(32'h7FFF_FFFF, 1'b1);
    drain_all();

    // zero keep_count acts as one
    reg_write(32'd0);
    send_score(32'd7, 1'b0);
    send_score(32'd9, 1'b0);
    send_score(32'd9, 1'b1);
    drain_all();

    for (int p = 0; p < 8; p++) begin
      reg_write(APB_DW'(keep_plan[p]));
      no_idle = (p % 3 == 2);
      random_phase(keep_plan[p]);
      no_idle = 1'b0;
      drain_all();
    end

    // result side held off while streams keep coming; input must back up
    reg_write(32'd32);
    no_idle = 1'b1;
    hold_tokens = hold_tokens + 1;
    for (int s = 0; s < 3; s++)
      for (int i = 0; i < 10; i++) send_score(rand_score(), i == 9);
    no_idle = 1'b0;
    drain_all();

    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
